>>> hw/rtl/rcpms_pkg.sv
// ----------------------------------------------------------------------------
// rcpms_pkg
// shared types and constants of the servo pulse multi-switch
// ----------------------------------------------------------------------------
`default_nettype none

package rcpms_pkg;

    localparam int NUM_SWITCHES_DEF = 7;
    localparam int OUT_BITS         = 7;
    localparam int SEL_BITS         = 4;
    localparam int LEN_BITS         = 8;
    localparam int CFG_IDX_BITS     = 2;
    localparam int IN_TDATA_BITS    = 8;
    localparam int OUT_TDATA_BITS   = 24;

    localparam logic [LEN_BITS-1:0] FWD_THRESH_RST  = 8'd27;
    localparam logic [LEN_BITS-1:0] NEUT_UPPER_RST  = 8'd26;
    localparam logic [LEN_BITS-1:0] NEUT_LOWER_RST  = 8'd20;
    localparam logic [LEN_BITS-1:0] BACK_THRESH_RST = 8'd19;
    localparam logic [SEL_BITS-1:0] SEL_MAX         = 4'd15;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FWD_THRESH  = 2'd0,
        REG_NEUT_UPPER  = 2'd1,
        REG_NEUT_LOWER  = 2'd2,
        REG_BACK_THRESH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_UNDEF = 2'd0,
        DIR_BACK  = 2'd1,
        DIR_NEUT  = 2'd2,
        DIR_FWD   = 2'd3
    } dir_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] fwd_thresh;
        logic [LEN_BITS-1:0] neut_upper;
        logic [LEN_BITS-1:0] neut_lower;
        logic [LEN_BITS-1:0] back_thresh;
    } thresh_t;

endpackage

`default_nettype wire

>>> hw/rtl/rcpms_classify.sv
// ----------------------------------------------------------------------------
// rcpms_classify
// sorts a captured pulse length into backward, neutral, forward or undefined
// ----------------------------------------------------------------------------
`default_nettype none

module rcpms_classify (
    input  wire logic [rcpms_pkg::LEN_BITS-1:0] pulse_len,
    input  wire rcpms_pkg::thresh_t             thresh,
    output rcpms_pkg::dir_t                     dir
);
    import rcpms_pkg::*;

    // forward first, then neutral, then backward
    always_comb begin
        if (pulse_len > thresh.fwd_thresh) begin
            dir = DIR_FWD;
        end else if (pulse_len < thresh.neut_upper && pulse_len > thresh.neut_lower) begin
            dir = DIR_NEUT;
        end else if (pulse_len < thresh.back_thresh) begin
            dir = DIR_BACK;
        end else begin
            dir = DIR_UNDEF;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rc_pulse_multi_switch.sv
// ----------------------------------------------------------------------------
// rc_pulse_multi_switch
// servo pulse decoder driving a row of toggled switch outputs
// ----------------------------------------------------------------------------
// Each input transaction is one sample of the pulse line at one timer tick and
// yields exactly one result transaction in the next cycle, with the switch
// state and selection after that tick plus the length and class of a pulse
// that ended on it. A new sample is taken every cycle unless a held result
// stalls: combinational edge, count and classify logic feeds the result
// register, which holds a result while m_tready is low, so throughput is one
// transaction per cycle when not stalled. The user writes thresholds via the
// cfg port only while the stream is idle; the block does not enforce this.
`default_nettype none

module rc_pulse_multi_switch #(
    parameter int NUM_SWITCHES = rcpms_pkg::NUM_SWITCHES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [rcpms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [rcpms_pkg::LEN_BITS-1:0]        cfg_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [0] ppm_level
    input  wire logic [rcpms_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [6:0] switch_outputs, [10:7] selection, [12:11] pulse_direction,
    // [13] pulse_done, [21:14] captured pulse ticks
    output logic [rcpms_pkg::OUT_TDATA_BITS-1:0]       m_tdata
);
    import rcpms_pkg::*;

    localparam logic [SEL_BITS-1:0] NUM_SW = SEL_BITS'(NUM_SWITCHES);
    localparam logic [SEL_BITS-1:0] OUT_CNT = SEL_BITS'(OUT_BITS);

    thresh_t              thresh_reg;
    logic                 prev_level_reg, prev_level_next;
    logic                 armed_reg, armed_next;
    logic [LEN_BITS-1:0]  tick_reg, tick_next;
    dir_t                 last_dir_reg, last_dir_next;
    logic [SEL_BITS-1:0]  sel_reg, sel_next;
    logic [OUT_BITS-1:0]  sw_reg, sw_next;
    logic                 m_valid_reg;
    logic [OUT_TDATA_BITS-1:0] m_data_reg, m_data_next;

    logic                 in_acc;
    logic                 level;
    logic                 rise;
    logic                 fall;
    logic                 done;
    logic [LEN_BITS-1:0]  tick_inc;
    logic [SEL_BITS-1:0]  sel_m1;
    dir_t                 cur_dir;
    dir_t                 dir_out;
    logic [LEN_BITS-1:0]  len_out;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign level    = s_tdata[0];
    assign rise     = !prev_level_reg && level;
    assign fall     = prev_level_reg && !level;
    assign tick_inc = tick_reg + LEN_BITS'(1);
    assign sel_m1   = sel_reg - SEL_BITS'(1);

    rcpms_classify u_classify (
        .pulse_len (tick_inc),
        .thresh    (thresh_reg),
        .dir       (cur_dir)
    );

    always_comb begin
        prev_level_next = level;
        armed_next      = armed_reg;
        tick_next       = tick_inc;
        last_dir_next   = last_dir_reg;
        sel_next        = sel_reg;
        sw_next         = sw_reg;
        done            = 1'b0;
        dir_out         = DIR_UNDEF;
        len_out         = '0;
        if (rise && !armed_reg) begin
            tick_next  = '0;
            armed_next = 1'b1;
        end else if (fall && armed_reg) begin
            armed_next = 1'b0;
            done       = 1'b1;
            dir_out    = cur_dir;
            len_out    = tick_inc;
            if (last_dir_reg == DIR_NEUT && cur_dir == DIR_FWD) begin
                if (sel_reg <= NUM_SW && sel_reg < SEL_MAX) begin
                    sel_next = sel_reg + SEL_BITS'(1);
                end
            end else if (last_dir_reg == DIR_NEUT && cur_dir == DIR_BACK) begin
                if (sel_reg == '0) begin
                    sw_next = '0;
                end else if (sel_reg <= NUM_SW && sel_reg <= OUT_CNT) begin
                    sw_next = sw_reg ^ (OUT_BITS'(1) << sel_m1[2:0]);
                end
                sel_next = '0;
            end
            if (cur_dir != DIR_UNDEF) begin
                last_dir_next = cur_dir;
            end
        end
        m_data_next = {2'b00, len_out, done, dir_out, sel_next, sw_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.fwd_thresh  <= FWD_THRESH_RST;
            thresh_reg.neut_upper  <= NEUT_UPPER_RST;
            thresh_reg.neut_lower  <= NEUT_LOWER_RST;
            thresh_reg.back_thresh <= BACK_THRESH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FWD_THRESH:  thresh_reg.fwd_thresh  <= cfg_data;
                REG_NEUT_UPPER:  thresh_reg.neut_upper  <= cfg_data;
                REG_NEUT_LOWER:  thresh_reg.neut_lower  <= cfg_data;
                REG_BACK_THRESH: thresh_reg.back_thresh <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            armed_reg      <= 1'b0;
            tick_reg       <= '0;
            last_dir_reg   <= DIR_UNDEF;
            sel_reg        <= '0;
            sw_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (in_acc) begin
                prev_level_reg <= prev_level_next;
                armed_reg      <= armed_next;
                tick_reg       <= tick_next;
                last_dir_reg   <= last_dir_next;
                sel_reg        <= sel_next;
                sw_reg         <= sw_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            m_data_reg <= m_data_next;
        end
    end

    // selection never passes one beyond the last switch
    a_sel_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, sel_reg} <= (SEL_BITS+1)'(NUM_SWITCHES + 1))
        else $error("selection beyond ceiling");

    // a captured pulse disarms the capture
    a_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && fall && armed_reg) |=> !armed_reg)
        else $error("capture still armed after pulse end");

    // an arming edge restarts the tick counter
    a_tick_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && rise && !armed_reg) |=> (armed_reg && tick_reg == '0))
        else $error("tick counter not cleared on rising edge");

    // switch state only moves with an input transaction
    a_sw_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_acc |=> $stable(sw_reg))
        else $error("switch outputs changed without a transaction");

endmodule

`default_nettype wire
